// File: rtl/pti_pkg.sv
// Shared types and constants for the pose time interpolator.
// No dependencies; used by pti_muldiv and pose_time_interpolator_core.
package pti_pkg;

  localparam int QUEUE_DEPTH = 16;

  localparam int TW   = 32;               // stamp width
  localparam int PW   = 32;               // position width
  localparam int HW   = 19;               // stored heading width
  localparam int OHW  = 21;               // output heading width
  localparam int RECW = TW + 2 * PW + HW; // one sample: t, x, y, heading
  localparam int VW   = 35;               // signed working value width
  localparam int MW   = VW - 1;           // magnitude of a value difference
  localparam int DTW  = TW + 1;           // signed stamp difference width
  localparam int QW   = 36;               // quotient width before capping
  localparam int SW   = QW + 2;           // width of the final sum

  localparam logic [15:0] THRESH_RST = 16'd7;

  localparam logic signed [VW-1:0] YAW_HALF_PI       = VW'(102944);
  localparam logic signed [VW-1:0] YAW_THREE_HALF_PI = VW'(308831);
  localparam logic signed [VW-1:0] YAW_TWO_PI        = VW'(411775);

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  typedef struct packed {
    logic [MW-1:0]  a;   // |dv|
    logic [DTW-1:0] b;   // |dt|
    logic [DTW-1:0] s;   // |span|
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

// File: rtl/pti_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/pti_muldiv.sv
// Sequential unit: shift-add multiply |dv|*|dt|, then restoring divide of
// (2p + s) by 2s, quotient capped at 2^(QW-1). Depends on pti_pkg.
module pti_muldiv (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  pti_pkg::md_req_t        req_i,
  output pti_pkg::md_stat_t       stat_o,
  output logic [pti_pkg::QW-1:0]  q_o
);

  localparam int AW  = pti_pkg::MW + pti_pkg::DTW;  // product width
  localparam int NW  = AW + 1;                      // numerator width
  localparam int RW  = pti_pkg::DTW + 1;            // remainder / divisor width
  localparam int CNW = $clog2(NW);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_e;

  state_e                  state_q, state_d;
  logic [CNW-1:0]          cnt_q, cnt_d;
  logic [pti_pkg::MW-1:0]  a_q, a_d;
  logic [pti_pkg::DTW-1:0] b_q, b_d;
  logic [pti_pkg::DTW-1:0] s_q, s_d;
  logic [AW-1:0]           acc_q, acc_d;
  logic [NW-1:0]           num_q, num_d;
  logic [RW-1:0]           rem_q, rem_d;
  logic [pti_pkg::QW-1:0]  qt_q, qt_d;
  logic                    sat_q, sat_d;
  logic [RW:0]             rem_sh;
  logic [RW:0]             den;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    s_d     = s_q;
    acc_d   = acc_q;
    num_d   = num_q;
    rem_d   = rem_q;
    qt_d    = qt_q;
    sat_d   = sat_q;
    rem_sh  = {rem_q, num_q[NW-1]};
    den     = {1'b0, s_q, 1'b0};
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          a_d     = req_i.a;
          b_d     = req_i.b;
          s_d     = req_i.s;
          acc_d   = '0;
          cnt_d   = CNW'(pti_pkg::DTW - 1);
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        acc_d = {acc_q[AW-2:0], 1'b0} + (b_q[pti_pkg::DTW-1] ? AW'(a_q) : '0);
        b_d   = {b_q[pti_pkg::DTW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          num_d   = {acc_d, 1'b0} + NW'(s_q);
          rem_d   = '0;
          qt_d    = '0;
          sat_d   = 1'b0;
          cnt_d   = CNW'(NW - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        sat_d = sat_q | qt_q[pti_pkg::QW-1];
        if (rem_sh >= den) begin
          rem_d = RW'(rem_sh - den);
          qt_d  = {qt_q[pti_pkg::QW-2:0], 1'b1};
        end else begin
          rem_d = RW'(rem_sh);
          qt_d  = {qt_q[pti_pkg::QW-2:0], 1'b0};
        end
        num_d = {num_q[NW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    s_q   <= s_d;
    acc_q <= acc_d;
    num_q <= num_d;
    rem_q <= rem_d;
    qt_q  <= qt_d;
  end

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = (state_q == S_DONE);
  assign q_o = (sat_q || qt_q[pti_pkg::QW-1]) ? {1'b1, {(pti_pkg::QW-1){1'b0}}} : qt_q;

endmodule

// File: rtl/pose_time_interpolator_core.sv
// Pose time interpolator top level: sample queue in RAM, bracket scan and
// per-channel interpolation. Depends on pti_pkg, pti_ram, pti_muldiv.
//
// A push request (tuser 0) is stored in the sample queue; when the queue is
// full the oldest sample is dropped. A query request (tuser 1) walks the queue
// once, one RAM read per cycle, then works x, y and heading in turn through
// one shared multiply/divide unit; a channel takes a shortcut for equal values
// or a change below the threshold, equal bracket times, or a query stamp equal
// to the lower stamp. A query on an empty queue answers with status set and
// zero data. A new request is taken while the previous result still waits on
// the output register.
module pose_time_interpolator_core #(
  parameter int QUEUE_DEPTH = pti_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,     // equal_threshold
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,    // stamp, pos_x, pos_y, heading, zero pad
  input  logic         s_axis_tuser,    // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata     // interp_x, interp_y, interp_heading, status, pad
);

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int RECW = pti_pkg::RECW;
  localparam int VW   = pti_pkg::VW;
  localparam int SW   = pti_pkg::SW;
  localparam int PW   = pti_pkg::PW;
  localparam int TW   = pti_pkg::TW;
  localparam int DTW  = pti_pkg::DTW;
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
  localparam logic signed [SW-1:0] P_HI = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] P_LO = -SW'(64'sd2147483648);
  localparam logic signed [SW-1:0] H_HI = SW'(64'sd1048575);
  localparam logic signed [SW-1:0] H_LO = -SW'(64'sd1048576);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PREP, S_WAIT, S_DONE} state_e;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] sat_val(input logic signed [SW-1:0] v,
                                            input logic is_h);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = is_h ? H_HI : P_HI;
    lo = is_h ? H_LO : P_LO;
    if (v > hi) sat_val = PW'(hi);
    else if (v < lo) sat_val = PW'(lo);
    else sat_val = PW'(v);
  endfunction

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     head_q, head_d;
  logic [15:0]       thr_q;
  logic [RECW-1:0]   lower_q, lower_d, upper_q, upper_d;
  logic [TW-1:0]     stamp_q, stamp_d;
  logic [CW-1:0]     iss_q, iss_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic              rd_vld_q, rd_vld_d;
  logic              up_found_q, up_found_d;
  logic [1:0]        ch_q, ch_d;
  logic [PW-1:0]     res_q [3];
  logic [PW-1:0]     res_d [3];
  logic              neg_q, neg_d;
  logic              status_q, status_d;
  logic              out_vld_q, out_vld_d;
  logic [87:0]       out_data_q, out_data_d;

  logic              s_fire;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW:0]       wsum;
  logic              re;
  logic [RECW-1:0]   rd_data;
  logic [RECW-1:0]   in_rec;

  logic signed [VW-1:0]  v1, v2, h1, h2, dv;
  logic signed [DTW-1:0] dt, span;
  logic [pti_pkg::MW-1:0] dvm;
  logic [TW-1:0]     t1, t2;
  logic              is_h;
  logic              md_start;
  pti_pkg::md_req_t  md_req;
  pti_pkg::md_stat_t md_stat;
  logic [pti_pkg::QW-1:0] md_q;
  logic signed [SW-1:0] v1_ext, v2_ext, fin;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_rec        = s_axis_tdata[RECW-1:0];
  assign wsum          = {1'b0, head_q} + (AW + 1)'(count_q);
  assign we            = s_fire && (s_axis_tuser == pti_pkg::OP_PUSH);
  always_comb begin
    if (count_q == FULL) waddr = head_q;
    else if (wsum >= (AW + 1)'(QUEUE_DEPTH)) waddr = AW'(wsum - (AW + 1)'(QUEUE_DEPTH));
    else waddr = AW'(wsum);
  end
  assign re = (state_q == S_SCAN) && (iss_q != count_q);

  pti_ram #(.WIDTH(RECW), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_rec),
    .re_i    (re),
    .raddr_i (ptr_q),
    .rdata_o (rd_data)
  );

  // channel operands
  assign t1   = lower_q[TW-1:0];
  assign t2   = upper_q[TW-1:0];
  assign is_h = (ch_q == 2'd2);
  always_comb begin
    h1 = VW'(lower_q[RECW-1 -: pti_pkg::HW]);
    h2 = VW'(upper_q[RECW-1 -: pti_pkg::HW]);
    if (h1 > pti_pkg::YAW_THREE_HALF_PI && h2 > 0 && h2 < pti_pkg::YAW_HALF_PI)
      h2 = h2 + pti_pkg::YAW_TWO_PI;
    else if (h1 < pti_pkg::YAW_HALF_PI && h2 < pti_pkg::YAW_TWO_PI &&
             h2 > pti_pkg::YAW_THREE_HALF_PI)
      h2 = h2 - pti_pkg::YAW_TWO_PI;
    case (ch_q)
      2'd0: begin
        v1 = VW'(signed'(lower_q[TW +: PW]));
        v2 = VW'(signed'(upper_q[TW +: PW]));
      end
      2'd1: begin
        v1 = VW'(signed'(lower_q[TW + PW +: PW]));
        v2 = VW'(signed'(upper_q[TW + PW +: PW]));
      end
      default: begin
        v1 = h1;
        v2 = h2;
      end
    endcase
  end
  assign dv     = v2 - v1;
  assign dvm    = dv[VW-1] ? pti_pkg::MW'(-dv) : pti_pkg::MW'(dv);
  assign dt     = signed'({1'b0, stamp_q}) - signed'({1'b0, t1});
  assign span   = signed'({1'b0, t2}) - signed'({1'b0, t1});
  assign v1_ext = SW'(v1);
  assign v2_ext = SW'(v2);
  assign fin    = neg_q ? v1_ext - signed'(SW'(md_q)) : v1_ext + signed'(SW'(md_q));

  assign md_req.a = dvm;
  assign md_req.b = dt[DTW-1] ? DTW'(-dt) : DTW'(dt);
  assign md_req.s = span[DTW-1] ? DTW'(-span) : DTW'(span);

  pti_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .req_i   (md_req),
    .stat_o  (md_stat),
    .q_o     (md_q)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    head_d     = head_q;
    lower_d    = lower_q;
    upper_d    = upper_q;
    stamp_d    = stamp_q;
    iss_d      = iss_q;
    ptr_d      = ptr_q;
    rd_vld_d   = 1'b0;
    up_found_d = up_found_q;
    ch_d       = ch_q;
    res_d      = res_q;
    neg_d      = neg_q;
    status_d   = status_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    md_start   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_fire && s_axis_tuser == pti_pkg::OP_PUSH) begin
          if (count_q == FULL) head_d = ptr_inc(head_q);
          else count_d = count_q + 1'b1;
          lower_d = upper_q;
          upper_d = in_rec;
        end else if (s_fire) begin
          stamp_d = in_rec[TW-1:0];
          if (count_q == '0) begin
            status_d = pti_pkg::ST_EMPTY;
            res_d    = '{default: '0};
            state_d  = S_DONE;
          end else begin
            iss_d      = '0;
            ptr_d      = head_q;
            up_found_d = 1'b0;
            state_d    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (re) begin
          ptr_d    = ptr_inc(ptr_q);
          iss_d    = iss_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          if (rd_data[TW-1:0] <= stamp_q) lower_d = rd_data;
          if (!up_found_q && rd_data[TW-1:0] >= stamp_q) begin
            upper_d    = rd_data;
            up_found_d = 1'b1;
          end
        end else if (!re) begin
          count_d  = '0;
          head_d   = '0;
          ch_d     = '0;
          status_d = pti_pkg::ST_OK;
          state_d  = S_PREP;
        end
      end
      S_PREP: begin
        if (dvm < pti_pkg::MW'(thr_q) || t1 == t2) begin
          res_d[ch_q] = sat_val(v2_ext, is_h);
          ch_d        = ch_q + 1'b1;
          if (is_h) state_d = S_DONE;
        end else if (dv == '0 || dt == '0) begin
          res_d[ch_q] = sat_val(v1_ext, is_h);
          ch_d        = ch_q + 1'b1;
          if (is_h) state_d = S_DONE;
        end else begin
          md_start = 1'b1;
          neg_d    = (dv[VW-1] ^ dt[DTW-1]) ^ span[DTW-1];
          state_d  = S_WAIT;
        end
      end
      S_WAIT: begin
        if (md_stat.done) begin
          res_d[ch_q] = sat_val(fin, is_h);
          ch_d        = ch_q + 1'b1;
          state_d     = is_h ? S_DONE : S_PREP;
        end
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_data_d = {2'b00, status_q, res_q[2][pti_pkg::OHW-1:0], res_q[1], res_q[0]};
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      head_q     <= '0;
      thr_q      <= pti_pkg::THRESH_RST;
      lower_q    <= '0;
      upper_q    <= '0;
      iss_q      <= '0;
      ptr_q      <= '0;
      rd_vld_q   <= 1'b0;
      up_found_q <= 1'b0;
      ch_q       <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      head_q     <= head_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      lower_q    <= lower_d;
      upper_q    <= upper_d;
      iss_q      <= iss_d;
      ptr_q      <= ptr_d;
      rd_vld_q   <= rd_vld_d;
      up_found_q <= up_found_d;
      ch_q       <= ch_d;
      out_vld_q  <= out_vld_d;
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q    <= stamp_d;
    res_q      <= res_d;
    neg_q      <= neg_d;
    status_q   <= status_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL) else $error("queue count above depth");

  a_md_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_start |-> !md_stat.busy) else $error("divider started while busy");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[85] == pti_pkg::ST_EMPTY) |-> m_axis_tdata[84:0] == '0)
    else $error("empty status with nonzero pose");

  a_scan_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && state_d == S_PREP) |=> count_q == '0 && head_q == '0)
    else $error("queue not cleared after scan");

endmodule

// File: dv/tb.sv
// Testbench for pose_time_interpolator_core: pushes odometry samples, queries
// poses, predicts each result in a local model and checks it field by field.
// Depends on rtl/pti_pkg.sv and rtl/pose_time_interpolator_core.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [20:0] h;
    logic        st;
  } pose_res_t;

  typedef struct {
    logic [31:0] t;
    longint      x;
    longint      y;
    longint      h;
  } sample_t;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     EXP_SLOTS   = 4096;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [15:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;

  pose_time_interpolator_core i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pose model
  sample_t   ring [pti_pkg::QUEUE_DEPTH];
  int        ring_count;
  int        ring_head;
  sample_t   lo_s;
  sample_t   up_s;
  logic [15:0] thresh;
  pose_res_t exp_slots [EXP_SLOTS];
  int        exp_wr = 0;
  int        exp_rd = 0;

  int     errors;
  int     hold_cycles;
  longint cycles;
  bit     traffic_done;

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint lerp(longint v1, longint v2, logic [31:0] t1,
                                  logic [31:0] t2, logic [31:0] t, longint lo,
                                  longint hi);
    longint dv, dt, span;
    logic [127:0] num, den, q;
    bit neg;
    dv = v2 - v1;
    dt = longint'({32'b0, t}) - longint'({32'b0, t1});
    span = longint'({32'b0, t2}) - longint'({32'b0, t1});
    if (mag(dv) < longint'({48'b0, thresh}) || t1 == t2) return sat(v2, lo, hi);
    if (dv == 0 || dt == 0) return sat(v1, lo, hi);
    num = ((128'(mag(dv)) * 128'(mag(dt))) << 1) + 128'(mag(span));
    den = 128'(mag(span)) << 1;
    q = num / den;
    if (q > (128'(1) << 62)) q = 128'(1) << 62;
    neg = ((dv < 0) != (dt < 0)) != (span < 0);
    return sat(neg ? v1 - longint'(q[63:0]) : v1 + longint'(q[63:0]), lo, hi);
  endfunction

  task automatic exp_put(pose_res_t r);
    exp_slots[exp_wr % EXP_SLOTS] = r;
    exp_wr++;
  endtask

  task automatic predict_pose(logic op, logic [31:0] stamp, logic [31:0] px,
                              logic [31:0] py, logic [18:0] hd);
    sample_t s;
    pose_res_t r;
    int lo_i, up_i, idx;
    longint h1, h2;
    lo_i = -1;
    up_i = -1;
    if (op == pti_pkg::OP_PUSH) begin
      s.t = stamp;
      s.x = longint'(signed'(px));
      s.y = longint'(signed'(py));
      s.h = longint'({45'b0, hd});
      if (ring_count >= pti_pkg::QUEUE_DEPTH) begin
        ring_head = (ring_head + 1) % pti_pkg::QUEUE_DEPTH;
        ring_count = pti_pkg::QUEUE_DEPTH - 1;
      end
      ring[(ring_head + ring_count) % pti_pkg::QUEUE_DEPTH] = s;
      ring_count++;
      lo_s = up_s;
      up_s = s;
      return;
    end
    if (ring_count == 0) begin
      r.x = '0; r.y = '0; r.h = '0; r.st = pti_pkg::ST_EMPTY;
      exp_put(r);
      return;
    end
    for (int i = 0; i < ring_count; i++) begin
      idx = (ring_head + i) % pti_pkg::QUEUE_DEPTH;
      if (ring[idx].t <= stamp) lo_i = idx;
      if (up_i < 0 && ring[idx].t >= stamp) up_i = idx;
    end
    if (lo_i >= 0) lo_s = ring[lo_i];
    if (up_i >= 0) up_s = ring[up_i];
    ring_count = 0;
    ring_head = 0;
    h1 = lo_s.h;
    h2 = up_s.h;
    if (h1 > 308831 && h2 > 0 && h2 < 102944) h2 += 411775;
    if (h1 < 102944 && h2 < 411775 && h2 > 308831) h2 -= 411775;
    r.x = 32'(lerp(lo_s.x, up_s.x, lo_s.t, up_s.t, stamp, -(64'sd1 <<< 31),
                   (64'sd1 <<< 31) - 1));
    r.y = 32'(lerp(lo_s.y, up_s.y, lo_s.t, up_s.t, stamp, -(64'sd1 <<< 31),
                   (64'sd1 <<< 31) - 1));
    r.h = 21'(lerp(h1, h2, lo_s.t, up_s.t, stamp, -(64'sd1 <<< 20),
                   (64'sd1 <<< 20) - 1));
    r.st = pti_pkg::ST_OK;
    exp_put(r);
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_req(logic op, logic [31:0] stamp, logic [31:0] px,
                          logic [31:0] py, logic [18:0] hd);
    int gap;
    bit rdy;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {5'b0, hd, py, px, stamp};
    // tready comes from a register, so its mid-cycle value holds at the next edge
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    predict_pose(op, stamp, px, py, hd);
  endtask

  task automatic push(logic [31:0] stamp, logic [31:0] px, logic [31:0] py,
                      logic [18:0] hd);
    send_req(pti_pkg::OP_PUSH, stamp, px, py, hd);
  endtask

  task automatic query(logic [31:0] stamp);
    send_req(pti_pkg::OP_QUERY, stamp, $urandom, $urandom, 19'($urandom));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_thresh(logic [15:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thresh = v;
  endtask

  function automatic logic [18:0] rand_heading();
    return $urandom_range(0, 9) == 0 ? 19'($urandom) : 19'($urandom_range(0, 411775));
  endfunction

  task automatic test_directed();
    query(32'd100);                       // empty queue
    push(32'd1000, 32'h0001_0000, 32'hFFFF_0000, 19'd1000);
    query(32'd1000);                      // single sample, equal bracket times
    push(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 19'd0);
    push(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 19'd411775);
    query(32'h8000_0000);                 // full-range interpolation
    push(32'd100, 32'd0, 32'd0, 19'd400000);
    push(32'd200, 32'd65536, 32'd3, 19'd1000);   // yaw wraps upward
    query(32'd150);
    push(32'd100, 32'd10, 32'd10, 19'd1000);
    push(32'd200, 32'd20, 32'd20, 19'd400000);   // yaw wraps downward
    query(32'd133);
    push(32'd500, 32'h7000_0000, 32'h9000_0000, 19'h7FFFF);
    push(32'd600, 32'h8000_0000, 32'h7FFF_FFFF, 19'd0);
    query(32'd10);                        // below all samples, stale lower
    for (int i = 0; i < 18; i++) push(32'(i * 10), 32'(i * 300000), -32'(i * 7), 19'(i * 20000));
    query(32'd1000);                      // above all after overflow drop
  endtask

  task automatic run_burst(int n_push);
    logic [31:0] t, t0, step;
    logic [31:0] x, y;
    t = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 100000);
    t0 = t;
    step = $urandom_range(0, 3) == 0 ? $urandom_range(0, 100000000) : $urandom_range(0, 500);
    x = $urandom;
    y = $urandom;
    for (int i = 0; i < n_push; i++) begin
      push(t, x, y, rand_heading());
      t += $urandom_range(0, step);
      x += $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 600000)) - 300000;
      y += 32'($urandom_range(0, 600000)) - 300000;
    end
    case ($urandom_range(0, 5))
      0: query($urandom);
      1: query(t0 - $urandom_range(0, 50));
      default: query(t0 + $urandom_range(0, t - t0));
    endcase
  endtask

  task automatic test_random(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1)) push($urandom, $urandom, $urandom, 19'($urandom));
        else query($urandom);
        sent++;
      end else begin
        int n;
        n = $urandom_range(0, 9) == 0 ? $urandom_range(14, 20) : $urandom_range(1, 6);
        run_burst(n);
        sent += n + 1;
      end
    end
  endtask

  task automatic test_thresholds();
    write_thresh(16'd0);
    test_random(150);
    write_thresh(16'hFFFF);
    test_random(150);
    write_thresh(16'($urandom));
    test_random(150);
    write_thresh(pti_pkg::THRESH_RST);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_cycles = 3000;
    for (int i = 0; i < 12; i++) run_burst($urandom_range(1, 4));
  endtask

  // result sink: random stalls, long hold-off while hold_cycles runs
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      int p;
      p = $urandom_range(0, 99);
      m_axis_tready <= traffic_done || p < 70 || (p >= 98 && m_axis_tready);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: unexpected pose result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        pose_res_t e;
        e = exp_slots[exp_rd % EXP_SLOTS];
        exp_rd++;
        if (m_axis_tdata[31:0] !== e.x) begin
          $display("%0t: interp_x exp %h got %h", $time, e.x, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== e.y) begin
          $display("%0t: interp_y exp %h got %h", $time, e.y, m_axis_tdata[63:32]);
          errors++;
        end
        if (m_axis_tdata[84:64] !== e.h) begin
          $display("%0t: interp_heading exp %h got %h", $time, e.h, m_axis_tdata[84:64]);
          errors++;
        end
        if (m_axis_tdata[85] !== e.st) begin
          $display("%0t: status exp %b got %b", $time, e.st, m_axis_tdata[85]);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    hold_cycles = 0;
    cycles = 0;
    traffic_done = 0;
    ring_count = 0;
    ring_head = 0;
    lo_s = '{t: 0, x: 0, y: 0, h: 0};
    up_s = lo_s;
    thresh = pti_pkg::THRESH_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_thresholds();
    test_backpressure();
    test_random(950);
    s_axis_tvalid <= 1'b0;
    traffic_done = 1;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0 && exp_wr == exp_rd) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/pti_pkg.sv
rtl/pti_ram.sv
rtl/pti_muldiv.sv
rtl/pose_time_interpolator_core.sv
dv/tb.sv
